// ===== src/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared widths, command and status codes, and cell control types for the
// ARP cache with aging.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int TIME_BITS     = 32;
  localparam int IP_W          = 32;
  localparam int MAC_W         = 48;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 2;
  localparam int TIMEOUT_W     = 16;
  localparam int AGE_W         = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(60);

  // request commands
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FORCE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP_IP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP_MAC = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd4;

  // response status
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // cell operations
  localparam logic [1:0] OP_IDLE    = 2'd0;
  localparam logic [1:0] OP_COMPACT = 2'd1;
  localparam logic [1:0] OP_MATCH   = 2'd2;
  localparam logic [1:0] OP_WRITE   = 2'd3;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [IP_W-1:0]      ip_t;
  typedef logic [MAC_W-1:0]     mac_t;
  typedef logic [TIME_BITS-1:0] stamp_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [TIMEOUT_W-1:0] timeout_t;

  typedef struct packed {
    logic   live;
    ip_t    ip;
    mac_t   mac;
    stamp_t stamp;
  } arpc_entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic [1:0] op;
    logic       by_mac;
    logic       wr_hit;
    logic       wr_append;
    ip_t        key_ip;
    mac_t       key_mac;
    stamp_t     now;
    timeout_t   timeout;
  } arpc_ctrl_t;

  // summary from the chain back to the sequencer
  typedef struct packed {
    logic                     any_dead;
    logic                     hit_any;
    logic                     full;
    ip_t                      ip;
    mac_t                     mac;
    logic [CACHE_ENTRIES-1:0] live_vec;
    logic [CACHE_ENTRIES-1:0] sel_vec;
  } arpc_stat_t;

endpackage

// ===== src/arpc_req_if.sv =====
// ----------------------------------------------------------------------------
// arpc_req_if
// Request channel: command with IP and MAC operands.
// ----------------------------------------------------------------------------
interface arpc_req_if;
  import arpc_pkg::*;

  logic valid;
  logic ready;
  cmd_t cmd;
  ip_t  ip_addr;
  mac_t mac_addr;

  modport source (output valid, cmd, ip_addr, mac_addr, input ready);
  modport sink   (input valid, cmd, ip_addr, mac_addr, output ready);
endinterface

// ===== src/arpc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// arpc_rsp_if
// Response channel: hit flag, looked-up addresses and status.
// ----------------------------------------------------------------------------
interface arpc_rsp_if;
  import arpc_pkg::*;

  logic    valid;
  logic    ready;
  logic    hit;
  mac_t    mac_out;
  ip_t     ip_out;
  status_t status;

  modport source (output valid, hit, mac_out, ip_out, status, input ready);
  modport sink   (input valid, hit, mac_out, ip_out, status, output ready);
endinterface

// ===== src/arpc_cell.sv =====
// ----------------------------------------------------------------------------
// arpc_cell
// One table slot: holds a binding, checks its own age, compares keys and
// pulls its upper neighbor down while a hole sits at or below it.
// ----------------------------------------------------------------------------
module arpc_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  arpc_pkg::arpc_ctrl_t  ctrl,
  input  arpc_pkg::arpc_entry_t upper,
  input  logic                  hole_in,
  input  logic                  found_in,
  input  logic                  prev_live,
  output arpc_pkg::arpc_entry_t entry,
  output logic                  hole_out,
  output logic                  found_out,
  output logic                  dead,
  output logic                  sel
);
  import arpc_pkg::*;

  stamp_t age;
  logic   match;
  logic   tail;

  assign age       = ctrl.now - entry.stamp;
  assign dead      = entry.live && (AGE_W'(age) > AGE_W'(ctrl.timeout));
  assign match     = entry.live && (ctrl.by_mac ? (entry.mac == ctrl.key_mac)
                                                : (entry.ip == ctrl.key_ip));
  assign hole_out  = hole_in | dead;
  assign found_out = found_in | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.live <= 1'b0;
      sel        <= 1'b0;
      tail       <= 1'b0;
    end else begin
      unique case (ctrl.op)
        OP_IDLE: begin
        end
        OP_COMPACT: begin
          // first hole and everything above it slide down one slot
          if (hole_in || dead) begin
            entry <= upper;
          end
        end
        OP_MATCH: begin
          sel  <= match && !found_in;
          tail <= !entry.live && prev_live;
        end
        OP_WRITE: begin
          if (ctrl.wr_hit && sel) begin
            entry.mac   <= ctrl.key_mac;
            entry.stamp <= ctrl.now;
          end
          if (ctrl.wr_append && tail) begin
            entry <= '{live: 1'b1, ip: ctrl.key_ip, mac: ctrl.key_mac, stamp: ctrl.now};
          end
        end
      endcase
    end
  end

endmodule

// ===== src/arpc_chain.sv =====
// ----------------------------------------------------------------------------
// arpc_chain
// Row of cells with the hole, first-match and tail chains, plus the
// gather of the selected entry.
// ----------------------------------------------------------------------------
module arpc_chain (
  input  logic                 clk,
  input  logic                 rst,
  input  arpc_pkg::arpc_ctrl_t ctrl,
  output arpc_pkg::arpc_stat_t stat
);
  import arpc_pkg::*;

  arpc_entry_t              entries [CACHE_ENTRIES];
  logic [CACHE_ENTRIES:0]   hole;
  logic [CACHE_ENTRIES:0]   found;
  logic [CACHE_ENTRIES-1:0] dead_vec;
  logic [CACHE_ENTRIES-1:0] sel_vec;
  logic [CACHE_ENTRIES-1:0] live_vec;

  assign hole[0]  = 1'b0;
  assign found[0] = 1'b0;

  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
    arpc_entry_t upper;
    logic        prev_live;

    if (i == CACHE_ENTRIES - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = entries[i+1];
    end

    if (i == 0) begin : g_first
      assign prev_live = 1'b1;
    end else begin : g_rest
      assign prev_live = entries[i-1].live;
    end

    arpc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .upper     (upper),
      .hole_in   (hole[i]),
      .found_in  (found[i]),
      .prev_live (prev_live),
      .entry     (entries[i]),
      .hole_out  (hole[i+1]),
      .found_out (found[i+1]),
      .dead      (dead_vec[i]),
      .sel       (sel_vec[i])
    );

    assign live_vec[i] = entries[i].live;
  end

  // sel is one-hot or empty, so an OR gather picks the matching entry
  always_comb begin
    stat.ip  = '0;
    stat.mac = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      stat.ip  = stat.ip  | (entries[i].ip  & {IP_W{sel_vec[i]}});
      stat.mac = stat.mac | (entries[i].mac & {MAC_W{sel_vec[i]}});
    end
    stat.any_dead = |dead_vec;
    stat.hit_any  = |sel_vec;
    stat.full     = live_vec[CACHE_ENTRIES-1];
    stat.live_vec = live_vec;
    stat.sel_vec  = sel_vec;
  end

endmodule

// ===== src/arp_cache_with_aging.sv =====
// ----------------------------------------------------------------------------
// arp_cache_with_aging
// IPv4-to-MAC binding table with per-entry time stamps and timeout purge.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+----------------------------------------
//  req       | in  | valid / ready | cmd, ip_addr, mac_addr
//  rsp       | out | valid / ready | hit, mac_out, ip_out, status
//  cfg       | in  | cfg_wr_en     | cfg_wr_data (timeout in seconds)
//
//  Insert and lookup enter the purge state: the compaction pass in the
//  cell row removes one expired entry per cycle, then keys are matched.
//  Tick and unused commands go straight to write. A full response register
//  holds the request in its write cycle until rsp is taken.
//  Reset empties the table, zeroes the clock and loads a 60 s timeout.
// ----------------------------------------------------------------------------
module arp_cache_with_aging (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  arpc_pkg::timeout_t        cfg_wr_data,
  arpc_req_if.sink                  req,
  arpc_rsp_if.source                rsp
);
  import arpc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PURGE = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  cmd_t       cmd_q;
  ip_t        ip_q;
  mac_t       mac_q;
  stamp_t     seconds_now;
  timeout_t   timeout;

  logic       out_valid;
  logic       out_hit;
  mac_t       out_mac;
  ip_t        out_ip;
  status_t    out_status;

  logic       res_hit;
  mac_t       res_mac;
  ip_t        res_ip;
  status_t    res_status;

  logic       slot_free;
  logic       fire;
  logic       tick_fire;
  logic       is_insert;

  arpc_ctrl_t ctrl;
  arpc_stat_t stat;

  arpc_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat)
  );

  assign req.ready  = (state == S_IDLE);
  assign slot_free  = !out_valid || rsp.ready;
  assign fire       = (state == S_WRITE) && slot_free;
  assign tick_fire  = fire && (cmd_q == CMD_TICK);
  assign is_insert  = (cmd_q == CMD_INSERT) || (cmd_q == CMD_FORCE);

  always_comb begin
    ctrl.op        = OP_IDLE;
    ctrl.by_mac    = (cmd_q == CMD_LOOKUP_MAC);
    ctrl.wr_hit    = is_insert && stat.hit_any;
    ctrl.wr_append = (cmd_q == CMD_FORCE) && !stat.hit_any && !stat.full;
    ctrl.key_ip    = ip_q;
    ctrl.key_mac   = mac_q;
    ctrl.now       = seconds_now;
    ctrl.timeout   = timeout;
    if (state == S_PURGE) begin
      ctrl.op = stat.any_dead ? OP_COMPACT : OP_MATCH;
    end else if (fire && is_insert) begin
      ctrl.op = OP_WRITE;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.cmd <= CMD_LOOKUP_MAC) ? S_PURGE : S_WRITE;
        end
      end
      S_PURGE: begin
        if (!stat.any_dead) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    res_hit    = 1'b0;
    res_mac    = '0;
    res_ip     = '0;
    res_status = ST_DONE;
    unique case (cmd_q)
      CMD_INSERT, CMD_FORCE: begin
        if (stat.hit_any) begin
          res_hit = 1'b1;
        end else if (cmd_q == CMD_INSERT) begin
          res_status = ST_MISS;
        end else if (stat.full) begin
          res_status = ST_FULL;
        end
      end
      CMD_LOOKUP_IP: begin
        res_hit    = stat.hit_any;
        res_mac    = stat.mac;
        res_status = stat.hit_any ? ST_DONE : ST_MISS;
      end
      CMD_LOOKUP_MAC: begin
        res_hit    = stat.hit_any;
        res_ip     = stat.ip;
        res_status = stat.hit_any ? ST_DONE : ST_MISS;
      end
      CMD_TICK: begin
      end
      default: res_status = ST_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      seconds_now <= '0;
      timeout     <= TIMEOUT_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      if (tick_fire) begin
        seconds_now <= seconds_now + 1'b1;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_q <= req.cmd;
      ip_q  <= req.ip_addr;
      mac_q <= req.mac_addr;
    end
    if (fire) begin
      out_hit    <= res_hit;
      out_mac    <= res_mac;
      out_ip     <= res_ip;
      out_status <= res_status;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.hit     = out_hit;
  assign rsp.mac_out = out_mac;
  assign rsp.ip_out  = out_ip;
  assign rsp.status  = out_status;

  logic [CACHE_ENTRIES:0] live_plus;
  assign live_plus = {1'b0, stat.live_vec} + 1'b1;

  // live entries always form an unbroken prefix of the row
  a_live_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot(live_plus))
    else $error("live entries not contiguous");

  // at most one first match is selected
  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> $onehot0(stat.sel_vec))
    else $error("more than one selected entry");

  // the table does not move while waiting for a request
  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(stat.live_vec))
    else $error("table changed while idle");

  // the clock only advances on a completed tick
  a_tick_only: assert property (@(posedge clk) disable iff (rst)
    (state != S_WRITE) |=> $stable(seconds_now))
    else $error("seconds counter moved outside a tick");

  // no lookup or insert is answered while an expired entry remains
  a_no_dead_on_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) && (cmd_q <= CMD_LOOKUP_MAC) |-> !stat.any_dead)
    else $error("expired entry survived purge");

endmodule
